[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, masked while arst_n is low.
`define AST_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define AST_NEVER(lbl, cond, msg) \
	`AST_HOLDS(lbl, !(cond), msg)

`endif

[sv/sng_pkg.sv]
`default_nettype none
package sng_pkg;

	localparam int unsigned TS_W   = 64;
	localparam int unsigned SEQ_W  = 64;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 6;

	// Positions in the unescaped NAL: prefix 0..4, RBSP 5..39
	localparam logic [IDX_W-1:0] RBSP_START = 6'd5;
	localparam logic [IDX_W-1:0] PTYPE_IDX  = 6'd5;
	localparam logic [IDX_W-1:0] PSIZE_IDX  = 6'd6;
	localparam logic [IDX_W-1:0] UUID_START = 6'd7;
	localparam logic [IDX_W-1:0] UUID_END   = 6'd22;
	localparam logic [IDX_W-1:0] TS_START   = 6'd23;
	localparam logic [IDX_W-1:0] TS_END     = 6'd30;
	localparam logic [IDX_W-1:0] SEQ_START  = 6'd31;
	localparam logic [IDX_W-1:0] SEQ_END    = 6'd38;
	localparam logic [IDX_W-1:0] LAST_IDX   = 6'd39;
	localparam logic [IDX_W-1:0] SC_ONE_IDX = 6'd3;
	localparam logic [IDX_W-1:0] HDR_IDX    = 6'd4;

	localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
	localparam logic [BYTE_W-1:0] SC_ONE     = 8'h01;
	localparam logic [BYTE_W-1:0] NAL_HDR    = 8'h06;
	localparam logic [BYTE_W-1:0] PTYPE_UDU  = 8'h05;
	localparam logic [BYTE_W-1:0] PSIZE      = 8'h20;
	localparam logic [BYTE_W-1:0] STOP_BYTE  = 8'h80;
	localparam logic [BYTE_W-1:0] EPB        = 8'h03;

	typedef struct packed {
		logic [TS_W-1:0]  stamp_us;
		logic [SEQ_W-1:0] seq_num;
	} sng_item_t;

	function automatic logic [BYTE_W-1:0] uuid_byte(input logic [3:0] k);
		logic [BYTE_W-1:0] b;
		case (k)
			4'd0:    b = 8'hB5;
			4'd1:    b = 8'h58;
			4'd2:    b = 8'h0A;
			4'd3:    b = 8'hB2;
			4'd4:    b = 8'h1C;
			4'd5:    b = 8'h7D;
			4'd6:    b = 8'h4E;
			4'd7:    b = 8'hF6;
			4'd8:    b = 8'h81;
			4'd9:    b = 8'h93;
			4'd10:   b = 8'hA4;
			4'd11:   b = 8'hC3;
			4'd12:   b = 8'hD7;
			4'd13:   b = 8'hE5;
			4'd14:   b = 8'hF2;
			default: b = 8'h9B;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

[sv/sng_queue.sv]
`default_nettype none
module sng_queue import sng_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire sng_item_t                    in_item,
	output      logic                         q_valid,
	output      sng_item_t                    q_item,
	input  wire logic                         q_pop,
	output      logic [$clog2(DEPTH+1)-1:0]   q_count
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sng_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready = (count_q != CNT_FULL);
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign q_count  = count_q;
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/sng_emit.sv]
`default_nettype none
module sng_emit import sng_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire sng_item_t         q_item,
	output      logic              q_pop,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [BYTE_W-1:0] out_byte,
	output      logic              last
);

	sng_item_t         item_q;
	logic              active_q;
	logic [IDX_W-1:0]  idx_q;
	logic [1:0]        zeros_q;
	logic              out_valid_q, last_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic [BYTE_W-1:0] raw;
	logic [IDX_W-1:0]  off;
	logic              adv, ins, fin;

	// Byte of the unescaped NAL at position idx_q
	always_comb begin
		off = '0;
		raw = ZERO_BYTE;
		case (idx_q) inside
			SC_ONE_IDX: raw = SC_ONE;
			HDR_IDX:    raw = NAL_HDR;
			PTYPE_IDX:  raw = PTYPE_UDU;
			PSIZE_IDX:  raw = PSIZE;
			[UUID_START:UUID_END]: begin
				off = idx_q - UUID_START;
				raw = uuid_byte(off[3:0]);
			end
			[TS_START:TS_END]: begin
				off = idx_q - TS_START;
				raw = item_q.stamp_us[{off[2:0], 3'b000} +: BYTE_W];
			end
			[SEQ_START:SEQ_END]: begin
				off = idx_q - SEQ_START;
				raw = item_q.seq_num[{off[2:0], 3'b000} +: BYTE_W];
			end
			LAST_IDX: raw = STOP_BYTE;
			default:  raw = ZERO_BYTE;
		endcase
	end

	assign adv   = active_q && (!out_valid_q || out_ready);
	assign ins   = (idx_q >= RBSP_START) && (zeros_q == 2'd2) && (raw <= EPB);
	assign fin   = adv && !ins && (idx_q == LAST_IDX);
	assign q_pop = q_valid && (!active_q || fin);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (adv) begin
			out_byte_q <= ins ? EPB : raw;
			last_q     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			zeros_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (ins) begin
					zeros_q <= '0;
				end else begin
					idx_q <= fin ? '0 : idx_q + 1'b1;
					if (idx_q < RBSP_START || raw != ZERO_BYTE) begin
						zeros_q <= '0;
					end else begin
						zeros_q <= zeros_q + 1'b1;
					end
				end
			end
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (fin) begin
				active_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
`default_nettype wire

[sv/sei_nal_emulation_prevent_gen_top.sv]
// Channel | Direction | Signals                            | Transaction
// --------+-----------+------------------------------------+----------------------------
// input   | in        | in_valid in_ready stamp_us seq_num | one item, one SEI NAL
// output  | out       | out_valid out_ready out_byte last  | one NAL byte, last on final
//
// Each item yields 40 to 47 output transactions, one byte per cycle while out_ready
// stays high; the byte sequencer sets this figure through the escape bytes it inserts.
// The first byte passes through the queue, the item register and the output register;
// a queued item follows the last byte of the previous NAL with no gap.
// The queue holds QUEUE_DEPTH items; in_ready drops while it is full and rises once the
// sequencer takes the next item at the end of a NAL.
// A stall on out_ready holds the output register and the sequencer; reset clears the
// queue pointers, the sequencer and the output valid flag.
`default_nettype none
`include "assert_macros.svh"
module sei_nal_emulation_prevent_gen_top import sng_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [TS_W-1:0]   stamp_us,
	input  wire logic [SEQ_W-1:0]  seq_num,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [BYTE_W-1:0] out_byte,
	output      logic              last
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

	sng_item_t        in_item, q_item;
	logic             q_valid, q_pop;
	logic [CNT_W-1:0] q_count;
	logic             nal_done, q_full;

	// Pack the input fields into one queue entry
	assign in_item = {stamp_us, seq_num};

	// Front: accept and hold items while the sequencer drains the current NAL
	sng_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.q_count  (q_count)
	);

	// Back: walk the NAL, insert emulation prevention bytes, drive the output register
	sng_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	assign nal_done = out_valid && out_ready && last;
	assign q_full   = (q_count == CNT_W'(QUEUE_DEPTH));

	// The final byte of every NAL is the RBSP stop byte
	`AST_NEVER(a_last_is_stop, out_valid && last && (out_byte != STOP_BYTE), "last not stop byte")
	// A new NAL always opens with a zero start code byte
	`AST_HOLDS(a_next_starts_zero, nal_done |=> (!out_valid || out_byte == ZERO_BYTE), "bad NAL start")
	// The queue never fills past its depth, and ready drops only when full
	`AST_HOLDS(a_queue_bound, (q_count <= CNT_W'(QUEUE_DEPTH)) && (in_ready || q_full), "queue count bad")

endmodule
`default_nettype wire
